### sv/aop_pkg.sv
// Shared types, constants and the microcode table of the box push-out search.
`default_nettype none
package aop_pkg;

  localparam int COORD_W    = 24;
  localparam int HALF_W     = 16;
  localparam int MAX_ROUNDS = 256;
  localparam int ROUND_W    = $clog2(MAX_ROUNDS + 1);
  localparam int AMT_W      = HALF_W + ROUND_W;
  localparam int SUM_W      = ((AMT_W > COORD_W) ? AMT_W : COORD_W) + 2;
  localparam int STEP_W     = 4;

  localparam logic [HALF_W-1:0] STEP_RESET = HALF_W'(26);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [HALF_W-1:0]         half_t;
  typedef logic [STEP_W-1:0]         upc_t;

  // axis indices into the coordinate vectors
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // micro-operations
  localparam logic [2:0] OP_TEST_START = 3'd0;
  localparam logic [2:0] OP_LOAD       = 3'd1;
  localparam logic [2:0] OP_TEST       = 3'd2;
  localparam logic [2:0] OP_ROUND      = 3'd3;
  localparam logic [2:0] OP_GIVEUP     = 3'd4;
  localparam logic [2:0] OP_EMIT       = 3'd5;

  // program addresses
  localparam upc_t UPC_START  = 4'd0;
  localparam upc_t UPC_LOOP   = 4'd1;
  localparam upc_t UPC_ROUND  = 4'd13;
  localparam upc_t UPC_GIVEUP = 4'd14;
  localparam upc_t UPC_EMIT   = 4'd15;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] axis;
    logic       neg;
    upc_t       target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input upc_t upc);
    ucode_t w;
    w = '{op: OP_EMIT, axis: AX_X, neg: 1'b0, target: UPC_EMIT};
    case (upc)
      4'd0:  w = '{op: OP_TEST_START, axis: AX_X, neg: 1'b0, target: UPC_EMIT};
      4'd1:  w = '{op: OP_LOAD,       axis: AX_X, neg: 1'b0, target: UPC_EMIT};
      4'd2:  w = '{op: OP_TEST,       axis: AX_X, neg: 1'b0, target: UPC_EMIT};
      4'd3:  w = '{op: OP_LOAD,       axis: AX_X, neg: 1'b1, target: UPC_EMIT};
      4'd4:  w = '{op: OP_TEST,       axis: AX_X, neg: 1'b1, target: UPC_EMIT};
      4'd5:  w = '{op: OP_LOAD,       axis: AX_Z, neg: 1'b0, target: UPC_EMIT};
      4'd6:  w = '{op: OP_TEST,       axis: AX_Z, neg: 1'b0, target: UPC_EMIT};
      4'd7:  w = '{op: OP_LOAD,       axis: AX_Z, neg: 1'b1, target: UPC_EMIT};
      4'd8:  w = '{op: OP_TEST,       axis: AX_Z, neg: 1'b1, target: UPC_EMIT};
      4'd9:  w = '{op: OP_LOAD,       axis: AX_Y, neg: 1'b0, target: UPC_EMIT};
      4'd10: w = '{op: OP_TEST,       axis: AX_Y, neg: 1'b0, target: UPC_EMIT};
      4'd11: w = '{op: OP_LOAD,       axis: AX_Y, neg: 1'b1, target: UPC_EMIT};
      4'd12: w = '{op: OP_TEST,       axis: AX_Y, neg: 1'b1, target: UPC_EMIT};
      4'd13: w = '{op: OP_ROUND,      axis: AX_X, neg: 1'b0, target: UPC_GIVEUP};
      4'd14: w = '{op: OP_GIVEUP,     axis: AX_X, neg: 1'b0, target: UPC_EMIT};
      4'd15: w = '{op: OP_EMIT,       axis: AX_X, neg: 1'b0, target: UPC_START};
      default: w = '{op: OP_EMIT, axis: AX_X, neg: 1'b0, target: UPC_EMIT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### sv/aop_box_test.sv
// Three-axis overlap test of two center/half-extent boxes; touching counts.
`default_nettype none
module aop_box_test
  import aop_pkg::*;
(
  input  coord_t [2:0] fc,
  input  half_t  [2:0] fh,
  input  coord_t [2:0] pc,
  input  half_t  [2:0] ph,
  output logic         hit
);

  logic [2:0] axis_hit;

  always_comb begin
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        mag;
    logic [HALF_W:0]         lim;
    diff     = '0;
    mag      = '0;
    lim      = '0;
    axis_hit = '0;
    for (int k = 0; k < 3; k++) begin
      diff = $signed({fc[k][COORD_W-1], fc[k]}) - $signed({pc[k][COORD_W-1], pc[k]});
      mag  = diff[COORD_W] ? (COORD_W+1)'(0) - diff : diff;
      lim  = {1'b0, fh[k]} + {1'b0, ph[k]};
      axis_hit[k] = (mag <= {{(COORD_W-HALF_W){1'b0}}, lim});
    end
  end

  assign hit = &axis_hit;

endmodule
`default_nettype wire

### sv/aabb_overlap_push_out_search.sv
// Top level of the box push-out search: microcoded sequencer and datapath.
//
// Usage: one input beat carries a fixed box and a probe box (centers signed
// Q15.8, half-extents Q.8). One output beat returns the probe center after
// push-out plus the was_overlapping and search_gave_up flags.
// Channels use valid/stall; a beat moves when valid is high and stall low.
// in_stall is high while an item is being searched. The result sits in an
// output register, so the next item is taken while a result waits.
// A probe that starts free goes from the start test straight to the emit
// step. Otherwise each search round runs six load/test pairs and one round
// update, and the step counter walks the microcode table; a search that
// finds no free spot in MAX_ROUNDS rounds gives up and returns the start.
// Reset (synchronous, rst_n low) clears the sequencer and output valid and
// loads step_amount with 26 (0.1 in Q.8). cfg_wr_en writes step_amount; write
// it only while the block is idle. A stalled output holds its beat and the
// sequencer waits in its emit step until the output register frees up.
`default_nettype none
module aabb_overlap_push_out_search
  import aop_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [15:0]  cfg_wr_data,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire coord_t       in_fixed_center_x,
  input  wire coord_t       in_fixed_center_y,
  input  wire coord_t       in_fixed_center_z,
  input  wire half_t        in_fixed_half_x,
  input  wire half_t        in_fixed_half_y,
  input  wire half_t        in_fixed_half_z,
  input  wire coord_t       in_probe_center_x,
  input  wire coord_t       in_probe_center_y,
  input  wire coord_t       in_probe_center_z,
  input  wire half_t        in_probe_half_x,
  input  wire half_t        in_probe_half_y,
  input  wire half_t        in_probe_half_z,
  output logic              out_valid,
  input  wire logic         out_stall,
  output coord_t            out_resolved_x,
  output coord_t            out_resolved_y,
  output coord_t            out_resolved_z,
  output logic              out_was_overlapping,
  output logic              out_search_gave_up
);

  localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(MAX_ROUNDS);

  // configuration
  half_t step_amount_r;

  // sequencer
  logic   busy_r, busy_nxt;
  upc_t   upc_r, upc_nxt;
  ucode_t uw;

  // datapath
  coord_t [2:0]       fc_r, pc_r, cand_r, cand_nxt;
  half_t  [2:0]       fh_r, ph_r;
  logic [AMT_W-1:0]   amt_r, amt_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic               over_r, over_nxt;
  logic               gave_up_r, gave_up_nxt;
  logic               hit;

  // output register
  logic   out_valid_r, out_valid_nxt;
  coord_t [2:0] res_r;
  logic   res_over_r, res_gave_up_r;
  logic   in_take, out_free, emit_go;

  assign uw       = ucode_rom(upc_r);
  assign in_stall = busy_r;
  assign in_take  = in_valid && !busy_r;
  assign out_free = !out_valid_r || !out_stall;
  assign emit_go  = busy_r && (uw.op == OP_EMIT) && out_free;

  aop_box_test u_box_test (
    .fc  (fc_r),
    .fh  (fh_r),
    .pc  (cand_r),
    .ph  (ph_r),
    .hit (hit)
  );

  // candidate: start position moved along one axis, saturated to Q15.8
  coord_t sat_coord;
  always_comb begin
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] delta;
    logic signed [SUM_W-1:0] sum;
    base  = SUM_W'($signed(pc_r[uw.axis]));
    delta = $signed({{(SUM_W-AMT_W){1'b0}}, amt_r});
    sum   = uw.neg ? base - delta : base + delta;
    if (sum[SUM_W-1:COORD_W-1] == '0 || sum[SUM_W-1:COORD_W-1] == '1) begin
      sat_coord = sum[COORD_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  // microcode execution
  always_comb begin
    busy_nxt    = busy_r;
    upc_nxt     = upc_r;
    cand_nxt    = cand_r;
    amt_nxt     = amt_r;
    round_nxt   = round_r;
    over_nxt    = over_r;
    gave_up_nxt = gave_up_r;
    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt    = 1'b1;
        upc_nxt     = UPC_START;
        cand_nxt    = {in_probe_center_z, in_probe_center_y, in_probe_center_x};
        amt_nxt     = AMT_W'(step_amount_r);
        round_nxt   = ROUND_W'(1);
        over_nxt    = 1'b0;
        gave_up_nxt = 1'b0;
      end
    end else begin
      upc_nxt = upc_r + STEP_W'(1);
      case (uw.op)
        OP_TEST_START: begin
          over_nxt = hit;
          if (!hit) begin
            upc_nxt = uw.target;
          end
        end
        OP_LOAD: begin
          cand_nxt          = pc_r;
          cand_nxt[uw.axis] = sat_coord;
        end
        OP_TEST: begin
          if (!hit) begin
            upc_nxt = uw.target;
          end
        end
        OP_ROUND: begin
          if (round_r == ROUND_LAST) begin
            upc_nxt = uw.target;
          end else begin
            amt_nxt   = amt_r + AMT_W'(step_amount_r);
            round_nxt = round_r + ROUND_W'(1);
            upc_nxt   = UPC_LOOP;
          end
        end
        OP_GIVEUP: begin
          gave_up_nxt = 1'b1;
          cand_nxt    = pc_r;
        end
        OP_EMIT: begin
          // hold here until the output register can take the beat
          upc_nxt = upc_r;
          if (out_free) begin
            busy_nxt = 1'b0;
            upc_nxt  = uw.target;
          end
        end
        default: begin
          upc_nxt = UPC_EMIT;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_amount_r <= STEP_RESET;
      busy_r        <= 1'b0;
      upc_r         <= UPC_START;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        step_amount_r <= cfg_wr_data;
      end
      busy_r      <= busy_nxt;
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      fc_r <= {in_fixed_center_z, in_fixed_center_y, in_fixed_center_x};
      fh_r <= {in_fixed_half_z, in_fixed_half_y, in_fixed_half_x};
      pc_r <= {in_probe_center_z, in_probe_center_y, in_probe_center_x};
      ph_r <= {in_probe_half_z, in_probe_half_y, in_probe_half_x};
    end
    cand_r    <= cand_nxt;
    amt_r     <= amt_nxt;
    round_r   <= round_nxt;
    over_r    <= over_nxt;
    gave_up_r <= gave_up_nxt;
    if (emit_go) begin
      res_r         <= cand_r;
      res_over_r    <= over_r;
      res_gave_up_r <= gave_up_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_resolved_x      = res_r[AX_X];
  assign out_resolved_y      = res_r[AX_Y];
  assign out_resolved_z      = res_r[AX_Z];
  assign out_was_overlapping = res_over_r;
  assign out_search_gave_up  = res_gave_up_r;

endmodule
`default_nettype wire

### tb/sv/aabb_overlap_push_out_search_tb.sv
// Self-checking testbench for the box push-out search block.
`timescale 1ns / 1ps
module aabb_overlap_push_out_search_tb;
  import aop_pkg::*;

  localparam longint COORD_LO  = -(longint'(1) << (COORD_W - 1));
  localparam longint COORD_HI  = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint HALF_MAX  = (longint'(1) << HALF_W) - 1;
  localparam int IDLE_PCT         = 23;
  localparam int PHASES           = 8;
  localparam int RANDOM_PER_PHASE = 198;
  localparam int DRAIN_CYCLES     = 16;
  // Even if every item gives up, the run stays under about 48 ms;
  // allow several times that.
  localparam longint TIMEOUT_NS = 250_000_000;

  // One query: fixed box and probe box, indexed by the package axis codes.
  typedef struct {
    coord_t fc [3];
    half_t  fh [3];
    coord_t pc [3];
    half_t  ph [3];
  } push_query_t;

  // One resolved position as the output beat carries it.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   over;
    logic   gave_up;
  } push_result_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_wr_en;
  logic   [HALF_W-1:0] cfg_wr_data;
  logic   in_valid;
  logic   in_stall;
  coord_t drv_fc [3];
  half_t  drv_fh [3];
  coord_t drv_pc [3];
  half_t  drv_ph [3];
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t out_resolved_x;
  coord_t out_resolved_y;
  coord_t out_resolved_z;
  logic   out_was_overlapping;
  logic   out_search_gave_up;

  // Local copy of the step register, updated with every write.
  logic [HALF_W-1:0] push_step;
  // Predicted positions, oldest first.
  push_result_t pending_positions [$];
  push_result_t head_position;
  int mismatch_count = 0;
  // Hold both sides busy (no idling) while set.
  bit steady_flow = 1'b0;

  aabb_overlap_push_out_search DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_fixed_center_x   (drv_fc[AX_X]),
    .in_fixed_center_y   (drv_fc[AX_Y]),
    .in_fixed_center_z   (drv_fc[AX_Z]),
    .in_fixed_half_x     (drv_fh[AX_X]),
    .in_fixed_half_y     (drv_fh[AX_Y]),
    .in_fixed_half_z     (drv_fh[AX_Z]),
    .in_probe_center_x   (drv_pc[AX_X]),
    .in_probe_center_y   (drv_pc[AX_Y]),
    .in_probe_center_z   (drv_pc[AX_Z]),
    .in_probe_half_x     (drv_ph[AX_X]),
    .in_probe_half_y     (drv_ph[AX_Y]),
    .in_probe_half_z     (drv_ph[AX_Z]),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_resolved_x      (out_resolved_x),
    .out_resolved_y      (out_resolved_y),
    .out_resolved_z      (out_resolved_z),
    .out_was_overlapping (out_was_overlapping),
    .out_search_gave_up  (out_search_gave_up)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic longint clamp_coord(longint v);
    if (v < COORD_LO) return COORD_LO;
    if (v > COORD_HI) return COORD_HI;
    return v;
  endfunction

  // Touching counts as overlap: on every axis the center gap must not exceed
  // the sum of the two half-extents.
  function automatic bit boxes_meet(push_query_t q, longint cx, longint cy, longint cz);
    longint c [3];
    longint gap;
    c[AX_X] = cx;
    c[AX_Y] = cy;
    c[AX_Z] = cz;
    for (int k = 0; k < 3; k++) begin
      gap = $signed(q.fc[k]) - c[k];
      if (gap < 0) gap = -gap;
      if (gap > longint'(q.fh[k]) + longint'(q.ph[k])) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Walk the rounds: distance grows by one step per round; inside a round try
  // +x, -x, +z, -z, +y, -y, each from the start, saturating the moved axis.
  function automatic push_result_t resolve_push(push_query_t q, logic [HALF_W-1:0] step);
    logic [1:0]   axis_seq [3];
    longint       start [3];
    longint       cand [3];
    longint       reach;
    push_result_t r;
    bit           found;
    axis_seq[0] = AX_X;
    axis_seq[1] = AX_Z;
    axis_seq[2] = AX_Y;
    for (int k = 0; k < 3; k++) start[k] = $signed(q.pc[k]);
    r.x       = q.pc[AX_X];
    r.y       = q.pc[AX_Y];
    r.z       = q.pc[AX_Z];
    r.over    = boxes_meet(q, start[AX_X], start[AX_Y], start[AX_Z]);
    r.gave_up = 1'b0;
    found     = 1'b0;
    if (r.over) begin
      for (int rnd = 0; rnd < MAX_ROUNDS && !found; rnd++) begin
        reach = longint'(step) * (rnd + 1);
        for (int a = 0; a < 3 && !found; a++) begin
          for (int s = 0; s < 2 && !found; s++) begin
            cand = start;
            cand[axis_seq[a]] = clamp_coord((s == 0) ? start[axis_seq[a]] + reach
                                                     : start[axis_seq[a]] - reach);
            if (!boxes_meet(q, cand[AX_X], cand[AX_Y], cand[AX_Z])) begin
              r.x   = coord_t'(cand[AX_X]);
              r.y   = coord_t'(cand[AX_Y]);
              r.z   = coord_t'(cand[AX_Z]);
              found = 1'b1;
            end
          end
        end
      end
      r.gave_up = !found;
    end
    return r;
  endfunction

  function automatic push_query_t box_pair(
    input longint fx, fy, fz, fhx, fhy, fhz, px, py, pz, phx, phy, phz
  );
    push_query_t q;
    q.fc[AX_X] = coord_t'(fx);   q.fc[AX_Y] = coord_t'(fy);   q.fc[AX_Z] = coord_t'(fz);
    q.fh[AX_X] = half_t'(fhx);   q.fh[AX_Y] = half_t'(fhy);   q.fh[AX_Z] = half_t'(fhz);
    q.pc[AX_X] = coord_t'(px);   q.pc[AX_Y] = coord_t'(py);   q.pc[AX_Z] = coord_t'(pz);
    q.ph[AX_X] = half_t'(phx);   q.ph[AX_Y] = half_t'(phy);   q.ph[AX_Z] = half_t'(phz);
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Drive one query beat at the falling edge, idle at random first, and hold
  // the payload until the block takes it. Valid stays high on return, so the
  // next call can follow back to back; anything else drops it first.
  task automatic send_box_pair(push_query_t q);
    @(negedge clk);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    for (int k = 0; k < 3; k++) begin
      drv_fc[k] = q.fc[k];
      drv_fh[k] = q.fh[k];
      drv_pc[k] = q.pc[k];
      drv_ph[k] = q.ph[k];
    end
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_positions.insert(pending_positions.size(), resolve_push(q, push_step));
  endtask

  // Write the step register only once every predicted beat has come back;
  // each item yields exactly one result, so the block is idle by then.
  task automatic write_step(logic [HALF_W-1:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    push_step = v;
  endtask

  // Randomly stall the result channel, except during the steady stretch.
  always @(negedge clk) out_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_positions.size() == 0) begin
        flag_mismatch("result beat with no query waiting");
      end else begin
        head_position = pending_positions.pop_front();
        check_field("resolved_x", out_resolved_x, head_position.x);
        check_field("resolved_y", out_resolved_y, head_position.y);
        check_field("resolved_z", out_resolved_z, head_position.z);
        check_field("was_overlapping", out_was_overlapping, head_position.over);
        check_field("search_gave_up", out_search_gave_up, head_position.gave_up);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Boxes apart on one axis, at opposite range ends, and one unit past touching.
  task automatic test_separated_boxes();
    send_box_pair(box_pair(0, 0, 0, 256, 256, 256, 5000, 0, 0, 256, 256, 256));
    send_box_pair(box_pair(COORD_LO, COORD_LO, COORD_LO, HALF_MAX, HALF_MAX, HALF_MAX,
                           COORD_HI, COORD_HI, COORD_HI, HALF_MAX, HALF_MAX, HALF_MAX));
    send_box_pair(box_pair(0, 0, 0, 256, 256, 256, 513, 0, 0, 256, 256, 256));
  endtask

  // Touching faces count as overlap; point boxes on the same center too.
  task automatic test_touching_edges();
    send_box_pair(box_pair(0, 0, 0, 256, 256, 256, 512, 0, 0, 256, 256, 256));
    send_box_pair(box_pair(0, 0, 0, 256, 256, 256, 0, 0, -512, 256, 256, 256));
    send_box_pair(box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Block every axis but one with the largest extents, so each direction wins
  // once; the last one only frees up in the second round.
  task automatic test_push_directions();
    send_box_pair(box_pair(0, 0, 0, 30, HALF_MAX, HALF_MAX, -20, 0, 0, 0, HALF_MAX, HALF_MAX));
    send_box_pair(box_pair(0, 0, 0, HALF_MAX, HALF_MAX, 10, 0, 0, 0, HALF_MAX, HALF_MAX, 0));
    send_box_pair(box_pair(0, 0, 0, HALF_MAX, HALF_MAX, 30, 0, 0, -20, HALF_MAX, HALF_MAX, 0));
    send_box_pair(box_pair(0, 0, 0, HALF_MAX, 10, HALF_MAX, 0, 0, 0, HALF_MAX, 0, HALF_MAX));
    send_box_pair(box_pair(0, 0, 0, HALF_MAX, 30, HALF_MAX, 0, -20, 0, HALF_MAX, 0, HALF_MAX));
    send_box_pair(box_pair(0, 0, 0, 40, HALF_MAX, HALF_MAX, 0, 0, 0, 0, HALF_MAX, HALF_MAX));
  endtask

  // Candidates past the Q15.8 range clamp; a clamped spot may be the free one.
  task automatic test_range_saturation();
    send_box_pair(box_pair(COORD_HI, COORD_HI, COORD_HI, 0, 0, 0,
                           COORD_HI, COORD_HI, COORD_HI, 0, 0, 0));
    send_box_pair(box_pair(COORD_HI - 20, 0, 0, 10, HALF_MAX, HALF_MAX,
                           COORD_HI - 20, 0, 0, 0, HALF_MAX, HALF_MAX));
    send_box_pair(box_pair(COORD_LO + 30, 0, 0, 20, HALF_MAX, HALF_MAX,
                           COORD_LO + 20, 0, 0, 0, HALF_MAX, HALF_MAX));
    send_box_pair(box_pair(0, 0, COORD_HI - 20, HALF_MAX, HALF_MAX, 10,
                           0, 0, COORD_HI - 20, HALF_MAX, HALF_MAX, 0));
  endtask

  // Largest boxes on one center cannot escape at the reset step.
  task automatic test_give_up();
    send_box_pair(box_pair(0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX,
                           0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX));
  endtask

  // Largest step, then smallest step.
  task automatic test_step_extremes();
    write_step(HALF_W'(HALF_MAX));
    send_box_pair(box_pair(0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX,
                           0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX));
    send_box_pair(box_pair(COORD_HI, COORD_HI, COORD_HI, HALF_MAX, HALF_MAX, HALF_MAX,
                           COORD_HI, COORD_HI, COORD_HI, HALF_MAX, HALF_MAX, HALF_MAX));
    write_step(HALF_W'(1));
    send_box_pair(box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_box_pair(box_pair(0, 0, 0, 3, HALF_MAX, HALF_MAX, 0, 0, 0, 0, HALF_MAX, HALF_MAX));
  endtask

  // A zero step never moves the probe: any overlap ends in giving up.
  task automatic test_zero_step();
    write_step('0);
    send_box_pair(box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_box_pair(box_pair(0, 0, 0, 1, 1, 1, 100, 0, 0, 1, 1, 1));
  endtask

  // Random phases at several step values. Most queries overlap with one
  // "easy" axis sized so the search ends within a dozen or so rounds; the
  // rest are full-range noise, touching/just-apart pairs, near-edge centers
  // and a few largest-box pairs that may give up at small steps.
  task automatic test_random_search();
    logic [HALF_W-1:0] phase_step [PHASES];
    push_query_t q;
    longint budget, lim, d, off;
    int pick, easy;
    phase_step[0] = HALF_W'($urandom_range(1, 64));
    phase_step[1] = HALF_W'(HALF_MAX);
    phase_step[2] = HALF_W'(1);
    phase_step[3] = HALF_W'($urandom_range(1, 65535));
    phase_step[4] = HALF_W'($urandom_range(100, 2000));
    phase_step[5] = STEP_RESET;
    phase_step[6] = HALF_W'($urandom_range(1, 65535));
    phase_step[7] = HALF_W'($urandom_range(1, 255));
    for (int phase = 0; phase < PHASES; phase++) begin
      write_step(phase_step[phase]);
      steady_flow = (phase == 5);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        budget = longint'(phase_step[phase]) * $urandom_range(1, 24) / 2;
        lim    = budget / 2;
        if (lim > HALF_MAX) lim = HALF_MAX;
        pick = $urandom_range(0, 99);
        easy = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
          q.fc[k] = coord_t'($urandom);
          q.fh[k] = half_t'($urandom);
          q.pc[k] = coord_t'($urandom);
          q.ph[k] = half_t'($urandom);
        end
        // Below 20: keep the full-range noise as drawn.
        if (pick >= 20) begin
          if ($urandom_range(0, 3) == 0) begin
            off = $urandom_range(0, 2 * int'(budget) + 2);
            q.fc[easy] = coord_t'($urandom_range(0, 1) ? COORD_HI - off : COORD_LO + off);
          end
          for (int k = 0; k < 3; k++) begin
            if (pick >= 28 && pick < 30) begin
              q.fh[k] = '1;
              q.ph[k] = '1;
            end else if (pick >= 30 && k == easy) begin
              q.fh[k] = half_t'($urandom_range(0, int'(lim)));
              q.ph[k] = half_t'($urandom_range(0, int'(lim)));
            end
            d = $urandom_range(0, int'(q.fh[k]) + int'(q.ph[k]));
            // Touching or one unit apart on the easy axis.
            if (pick < 28 && k == easy)
              d = longint'(q.fh[k]) + longint'(q.ph[k]) + $urandom_range(0, 1);
            if ($urandom_range(0, 1)) d = -d;
            q.pc[k] = coord_t'(clamp_coord($signed(q.fc[k]) + d));
          end
        end
        send_box_pair(q);
      end
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    for (int k = 0; k < 3; k++) begin
      drv_fc[k] = '0;
      drv_fh[k] = '0;
      drv_pc[k] = '0;
      drv_ph[k] = '0;
    end
    push_step = STEP_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_separated_boxes();
    test_touching_edges();
    test_push_directions();
    test_range_saturation();
    test_give_up();
    test_step_extremes();
    test_zero_step();
    test_random_search();

    // Drop valid, drain every predicted beat, then watch for strays.
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
